// ----- rtl/iras_pkg.sv -----
// Shared types, constants and helpers for the integer-to-ASCII formatter.
// No dependencies; iras_front, iras_back and the top level import this package.
`timescale 1ns / 1ps

package iras_pkg;

  localparam int S_TDATA_W     = 80;
  localparam int NUMBER_LSB    = 0;
  localparam int NUMBER_W      = 64;
  localparam int RADIX_LSB     = 64;
  localparam int RADIX_W       = 8;
  localparam int SIZE_LSB      = 72;
  localparam int SIZE_W        = 7;
  localparam int CHAR_W        = 8;
  localparam int DIGIT_W       = 4;
  localparam int BASE_W        = 5;
  localparam int COUNT_W       = 7;
  localparam int MAX_DIGITS    = 64;
  localparam int DIGIT_IDX_W   = 6;
  localparam int BITS_PER_STEP = 8;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [RADIX_W-1:0] RADIX_MIN     = 8'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX     = 8'd16;
  localparam logic [RADIX_W-1:0] RADIX_DECIMAL = 8'd10;
  localparam logic [COUNT_W-1:0] ROOM_LIMIT    = 7'd64;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS    = 8'h2D;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO     = 8'h30;
  localparam logic [CHAR_W-1:0]  CHAR_ALPHA    = 8'h41;
  localparam logic [CHAR_W-1:0]  CHAR_NUL      = 8'h00;

  typedef struct packed {
    logic                empty;
    logic                neg;
    logic [BASE_W-1:0]   base;
    logic [COUNT_W-1:0]  room;
  } job_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMPTY,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_LOAD
  } back_state_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_ALPHA + CHAR_W'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

// ----- rtl/integer_radix_to_ascii.sv -----
// Top level of the integer-to-ASCII formatter.
// Depends on iras_pkg, iras_front, iras_fifo, iras_back and iras_ram.
`timescale 1ns / 1ps

// Each input transaction carries a value, a signed flag, a radix and a buffer
// size, and produces the value's text as a run of output transactions, one
// ASCII character each, most significant digit first, the final one marked
// by tlast. A negative signed decimal value gets a leading '-'; a buffer of
// fewer than two bytes gives a single transaction with tuser set. A two-entry
// job queue lets the next input be taken while a number is being formatted.
// The back end works on one number at a time: the divider works out each digit
// in turn and stores it in the digit RAM, and each character is then read
// back from the RAM and loaded into the output register.

module integer_radix_to_ascii #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // number_bits[63:0], radix[71:64], buffer_size[78:72]
  input  logic        s_axis_tuser,  // is_signed
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // character[7:0]
  output logic        m_axis_tlast,  // last_char
  output logic        m_axis_tuser   // empty_text
);

  import iras_pkg::*;

  localparam int JOB_W = $bits(job_ctl_t) + VALUE_WIDTH;

  logic                   queue_full;
  logic                   push;
  job_ctl_t               push_ctl;
  logic [VALUE_WIDTH-1:0] push_mag;
  logic                   pop;
  logic                   pop_valid;
  logic [JOB_W-1:0]       pop_data;
  job_ctl_t               pop_ctl;
  logic [VALUE_WIDTH-1:0] pop_mag;

  assign pop_ctl = job_ctl_t'(pop_data[JOB_W-1:VALUE_WIDTH]);
  assign pop_mag = pop_data[VALUE_WIDTH-1:0];

  iras_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .queue_full    (queue_full),
    .push          (push),
    .push_ctl      (push_ctl),
    .push_mag      (push_mag)
  );

  iras_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_ctl, push_mag}),
    .full      (queue_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_data  (pop_data)
  );

  iras_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (pop_valid),
    .job_ctl       (pop_ctl),
    .job_mag       (pop_mag),
    .job_pop       (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ----- rtl/iras_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module iras_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/iras_fifo.sv -----
// Small job queue between the classifying front and the digit back end.
// No dependencies.
`timescale 1ns / 1ps

module iras_fifo #(
  parameter int WIDTH = 77,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;

  assign full      = (fill == CW'(DEPTH));
  assign pop_valid = (fill != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- rtl/iras_front.sv -----
// Input side: accepts transactions, picks the base, sign and digit room.
// Depends on iras_pkg.
`timescale 1ns / 1ps

module iras_front #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [iras_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  logic                           s_axis_tuser,
  input  logic                           queue_full,
  output logic                           push,
  output iras_pkg::job_ctl_t             push_ctl,
  output logic [VALUE_WIDTH-1:0]         push_mag
);

  import iras_pkg::*;

  logic [VALUE_WIDTH-1:0] value;
  logic [RADIX_W-1:0]     radix;
  logic [SIZE_W-1:0]      size;
  logic                   neg;
  logic [COUNT_W-1:0]     room_raw;

  assign value = s_axis_tdata[NUMBER_LSB +: VALUE_WIDTH];
  assign radix = s_axis_tdata[RADIX_LSB +: RADIX_W];
  assign size  = s_axis_tdata[SIZE_LSB +: SIZE_W];

  assign s_axis_tready = !queue_full;
  assign push          = s_axis_tvalid && !queue_full;

  always_comb begin
    neg      = s_axis_tuser && (radix == RADIX_DECIMAL) && value[VALUE_WIDTH-1];
    room_raw = neg ? (size - 7'd2) : (size - 7'd1);
    push_mag = neg ? (~value + 1'b1) : value;

    push_ctl.empty = (size < 7'd2);
    push_ctl.neg   = neg;
    if (radix < RADIX_MIN || radix > RADIX_MAX) begin
      push_ctl.base = BASE_W'(RADIX_DECIMAL);
    end else begin
      push_ctl.base = radix[BASE_W-1:0];
    end
    push_ctl.room = (room_raw > ROOM_LIMIT) ? ROOM_LIMIT : room_raw;
  end

endmodule

// ----- rtl/iras_back.sv -----
// Back end: divides the magnitude by the base eight bits per cycle, keeps the
// digits in a RAM and sends the text out most significant digit first.
// Depends on iras_pkg and iras_ram.
`timescale 1ns / 1ps

module iras_back #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         job_valid,
  input  iras_pkg::job_ctl_t           job_ctl,
  input  logic [VALUE_WIDTH-1:0]       job_mag,
  output logic                         job_pop,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [iras_pkg::CHAR_W-1:0]  m_axis_tdata,
  output logic                         m_axis_tlast,
  output logic                         m_axis_tuser
);

  import iras_pkg::*;

  localparam int PW     = ((VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP) * BITS_PER_STEP;
  localparam int STEPS  = PW / BITS_PER_STEP;
  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  back_state_t              state;
  back_state_t              state_next;
  job_ctl_t                 ctl;
  job_ctl_t                 ctl_next;
  logic [PW-1:0]            q;
  logic [PW-1:0]            q_next;
  logic [DIGIT_W-1:0]       rem;
  logic [DIGIT_W-1:0]       rem_next;
  logic [STEP_W-1:0]        step;
  logic [STEP_W-1:0]        step_next;
  logic [COUNT_W-1:0]       count;
  logic [COUNT_W-1:0]       count_next;
  logic [DIGIT_IDX_W-1:0]   idx;
  logic [DIGIT_IDX_W-1:0]   idx_next;
  logic                     out_valid_next;
  logic [CHAR_W-1:0]        out_char_next;
  logic                     out_last_next;
  logic                     out_empty_next;
  logic                     out_load;
  logic                     out_free;
  logic [DIGIT_W-1:0]       div_rem;
  logic [BITS_PER_STEP-1:0] div_qbits;
  logic [PW-1:0]            div_q;
  logic [BASE_W-1:0]        trial;
  logic                     ram_we;
  logic                     ram_re;
  logic [DIGIT_W-1:0]       ram_rdata;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    div_rem   = rem;
    div_qbits = '0;
    trial     = '0;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      trial = {div_rem, q[PW-1-i]};
      if (trial >= ctl.base) begin
        div_rem                          = DIGIT_W'(trial - ctl.base);
        div_qbits[BITS_PER_STEP-1-i] = 1'b1;
      end else begin
        div_rem = trial[DIGIT_W-1:0];
      end
    end
    div_q = (q << BITS_PER_STEP) | PW'(div_qbits);
  end

  iras_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_digits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[DIGIT_IDX_W-1:0]),
    .wdata (div_rem),
    .re    (ram_re),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next     = state;
    ctl_next       = ctl;
    q_next         = q;
    rem_next       = rem;
    step_next      = step;
    count_next     = count;
    idx_next       = idx;
    job_pop        = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    out_load       = 1'b0;
    out_char_next  = m_axis_tdata;
    out_last_next  = m_axis_tlast;
    out_empty_next = m_axis_tuser;

    unique case (state)
      ST_IDLE: begin
        if (job_valid) begin
          job_pop    = 1'b1;
          ctl_next   = job_ctl;
          q_next     = PW'(job_mag);
          rem_next   = '0;
          step_next  = '0;
          count_next = '0;
          if (job_ctl.empty) begin
            state_next = ST_EMPTY;
          end else if (job_ctl.room == '0) begin
            state_next = ST_SIGN;
          end else begin
            state_next = ST_DIV;
          end
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_char_next  = CHAR_NUL;
          out_last_next  = 1'b1;
          out_empty_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_DIV: begin
        q_next    = div_q;
        rem_next  = div_rem;
        step_next = step + 1'b1;
        if (step == STEP_W'(STEPS - 1)) begin
          ram_we     = 1'b1;
          count_next = count + 1'b1;
          rem_next   = '0;
          step_next  = '0;
          if (div_q == '0 || count_next >= ctl.room) begin
            idx_next   = count[DIGIT_IDX_W-1:0];
            state_next = ctl.neg ? ST_SIGN : ST_READ;
          end
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_char_next  = CHAR_MINUS;
          out_last_next  = (count == '0);
          out_empty_next = 1'b0;
          if (count == '0) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        ram_re     = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_char_next  = digit_char(ram_rdata);
          out_last_next  = (idx == '0);
          out_empty_next = 1'b0;
          if (idx == '0) begin
            state_next = ST_IDLE;
          end else begin
            idx_next   = idx - 1'b1;
            state_next = ST_READ;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    out_valid_next = out_load || (m_axis_tvalid && !m_axis_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step          <= '0;
      count         <= '0;
      idx           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state         <= state_next;
      step          <= step_next;
      count         <= count_next;
      idx           <= idx_next;
      m_axis_tvalid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ctl          <= ctl_next;
    q            <= q_next;
    rem          <= rem_next;
    m_axis_tdata <= out_char_next;
    m_axis_tlast <= out_last_next;
    m_axis_tuser <= out_empty_next;
  end

endmodule

// ----- sim/tb_integer_radix_to_ascii.sv -----
// Self-checking testbench for the integer-to-ASCII formatter.
// Drives number transactions, predicts the character stream and checks it;
// depends only on the integer_radix_to_ascii RTL and its package.
`timescale 1ns / 1ps

typedef struct {
  logic [7:0] ch;
  logic       last;
  logic       empty;
} ascii_char_t;

class ascii_scoreboard;
  ascii_char_t expected_chars[$];
  int          errors;

  function new();
    errors = 0;
  endfunction

  function int pending();
    return expected_chars.size();
  endfunction

  function void push_char(logic [7:0] ch, logic last, logic empty);
    ascii_char_t c;
    c.ch    = ch;
    c.last  = last;
    c.empty = empty;
    expected_chars.push_back(c);
  endfunction

  // Works out the text of one accepted number and queues its characters.
  function void note_number(logic [63:0] bits, logic sgn, logic [7:0] radix,
                            logic [6:0] size);
    string       hex_digits;
    logic [63:0] quo;
    logic [3:0]  digs[64];
    int unsigned base;
    int          room;
    int          ndig;
    int          sz;
    logic        neg;
    hex_digits = "0123456789ABCDEF";
    sz   = size;
    quo  = bits;
    ndig = 0;
    neg  = sgn && (radix == 8'd10) && bits[63];
    if (neg) begin
      if (sz < 2) begin
        push_char(8'h00, 1'b1, 1'b1);
        return;
      end
      quo = ~bits + 64'd1;
      sz  = sz - 1;
    end
    if (sz == 0) begin
      push_char(8'h00, 1'b1, 1'b1);
      return;
    end
    base = (radix < 8'd2 || radix > 8'd16) ? 10 : radix;
    room = sz - 1;
    do begin
      if (ndig >= room || ndig >= 64) break;
      digs[ndig] = 4'(quo % 64'(base));
      ndig++;
      quo = quo / 64'(base);
    end while (quo != 64'd0);
    if (!neg && ndig == 0) begin
      push_char(8'h00, 1'b1, 1'b1);
      return;
    end
    if (neg) push_char(8'h2D, ndig == 0, 1'b0);
    for (int k = ndig - 1; k >= 0; k--) begin
      push_char(hex_digits[digs[k]], k == 0, 1'b0);
    end
  endfunction

  function void check_char(logic [7:0] ch, logic last, logic empty);
    ascii_char_t want;
    if (expected_chars.size() == 0) begin
      errors++;
      $error("unexpected output transaction: character %h last %b empty %b",
             ch, last, empty);
      return;
    end
    want = expected_chars.pop_front();
    if (ch !== want.ch) begin
      errors++;
      $error("character: expected %h, got %h", want.ch, ch);
    end
    if (last !== want.last) begin
      errors++;
      $error("last_char: expected %b, got %b", want.last, last);
    end
    if (empty !== want.empty) begin
      errors++;
      $error("empty_text: expected %b, got %b", want.empty, empty);
    end
  endfunction
endclass

module tb_integer_radix_to_ascii;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  int send_idle_pct;
  int recv_stall_pct;

  ascii_scoreboard sb;

  integer_radix_to_ascii dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("integer_radix_to_ascii regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      sb.check_char(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_number(input logic [63:0] bits, input logic sgn,
                             input logic [7:0] radix, input logic [6:0] size);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, size, radix, bits};
    s_axis_tuser  <= sgn;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_number(bits, sgn, radix, size);
  endtask

  initial begin
    logic [63:0] bits;
    logic [7:0]  radix;
    logic [6:0]  size;
    logic        sgn;
    int          wait_cycles;
    sb             = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_number(64'd0, 1'b0, 8'd10, 7'd66);
    send_number(64'd0, 1'b0, 8'd10, 7'd1);
    send_number(64'd0, 1'b0, 8'd10, 7'd2);
    send_number('1, 1'b0, 8'd2, 7'd66);
    send_number('1, 1'b0, 8'd16, 7'd66);
    send_number('1, 1'b0, 8'd10, 7'd66);
    send_number(64'h8000_0000_0000_0000, 1'b1, 8'd10, 7'd66);
    send_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 8'd10, 7'd66);
    send_number('1, 1'b1, 8'd10, 7'd66);
    send_number('1, 1'b1, 8'd16, 7'd66);
    send_number('1, 1'b1, 8'd0, 7'd66);
    send_number(64'd987654321, 1'b0, 8'd0, 7'd20);
    send_number(64'd987654321, 1'b0, 8'd1, 7'd20);
    send_number(64'd987654321, 1'b0, 8'd17, 7'd20);
    send_number(64'd987654321, 1'b0, 8'd255, 7'd20);
    send_number(64'd987654321, 1'b0, 8'd3, 7'd66);
    send_number(64'd987654321, 1'b0, 8'd7, 7'd66);
    send_number(64'hDEAD_BEEF, 1'b1, 8'd8, 7'd66);
    send_number(64'd12345, 1'b0, 8'd10, 7'd0);
    send_number(64'd12345, 1'b0, 8'd10, 7'd3);
    send_number(-64'd12345, 1'b1, 8'd10, 7'd0);
    send_number(-64'd12345, 1'b1, 8'd10, 7'd1);
    send_number(-64'd12345, 1'b1, 8'd10, 7'd2);
    send_number(-64'd12345, 1'b1, 8'd10, 7'd3);
    send_number(64'h8000_0000_0000_0000, 1'b1, 8'd10, 7'd64);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      for (int n = 0; n < 86; n++) begin
        case ($urandom_range(4))
          0: bits = {$urandom, $urandom};
          1: bits = 64'($urandom_range(999));
          2: bits = -64'($urandom_range(999));
          3: bits = (64'd1 << $urandom_range(63)) - 64'($urandom_range(1));
          default: bits = {$urandom, $urandom} >> $urandom_range(63);
        endcase
        case ($urandom_range(9))
          0, 1, 2, 3: radix = 8'd10;
          4, 5, 6, 7: radix = 8'($urandom_range(2, 16));
          default: radix = 8'($urandom_range(255));
        endcase
        case ($urandom_range(9))
          0: size = 7'($urandom_range(0, 3));
          1: size = 7'($urandom_range(64, 66));
          default: size = 7'($urandom_range(2, 66));
        endcase
        sgn = 1'($urandom_range(1));
        send_number(bits, sgn, radix, size);
      end
    end
    s_axis_tvalid <= 1'b0;

    wait_cycles = 0;
    while (sb.pending() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (700) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.errors++;
      $error("%0d expected characters never arrived", sb.pending());
    end
    if (sb.errors == 0) begin
      $display("integer_radix_to_ascii regression: pass");
    end else begin
      $display("integer_radix_to_ascii regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/iras_pkg.sv
rtl/iras_ram.sv
rtl/iras_fifo.sv
rtl/iras_front.sv
rtl/iras_back.sv
rtl/integer_radix_to_ascii.sv
sim/tb_integer_radix_to_ascii.sv
